// ===== src/wmd_pkg.sv =====
`timescale 1ns / 1ps

package wmd_pkg;

	// Field widths and limits
	localparam int SAMPLE_BITS = 16;
	localparam int GAIN_W      = 16;
	localparam int GAIN_FRAC   = 8;
	localparam int NDC_W       = 16;
	localparam int MAX_SAMPLES = 1048576;
	localparam int MAX_COLUMNS = 4096;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 21;
	localparam int N_W        = 21;
	localparam int W_W        = 13;

	// Counter and stepping widths
	localparam int IDX_W  = $clog2(MAX_SAMPLES);
	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int SPC_W  = IDX_W + 1;
	localparam int XQ_W   = 17;
	localparam int XR_W   = IDX_W;
	localparam int X_ONE  = 65536;

	// Serial divider
	localparam int DIV_W     = N_W;
	localparam int DIV_STEPS = DIV_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Sample queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [NDC_W-1:0] ndc_t;

	localparam sample_t SAMP_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMP_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam ndc_t    NDC_HI  = {1'b0, {(NDC_W-1){1'b1}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_COUNT = 2'd0,
		REG_COLUMN_COUNT = 2'd1,
		REG_GAIN         = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_LINE = 2'd0,
		KIND_MIN  = 2'd1,
		KIND_MAX  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		SU_LOAD_SPC,
		SU_RUN_SPC,
		SU_LOAD_STEP,
		SU_RUN_STEP,
		SU_READY
	} setup_state_t;

	// Waveform geometry handed from setup to the back end
	typedef struct packed {
		logic              ready;
		logic              restart;
		logic              env;
		logic [SPC_W-1:0]  spc;
		logic [IDX_W-1:0]  n_last;
		logic [COL_W-1:0]  w_last;
		logic [XQ_W-1:0]   step_a;
		logic [XR_W-1:0]   step_b;
		logic [XR_W-1:0]   step_d;
	} geo_t;

	typedef struct packed {
		ndc_t    x;
		sample_t y;
		kind_t   kind;
		logic    run_last;
		logic    wave_last;
	} vtx_t;

	// Map floor(pos * 65536 / span) to Q1.15, saturating +1
	function automatic ndc_t ndc_from_q(input logic [XQ_W-1:0] q);
		ndc_t r;
		if (q[XQ_W-1]) begin
			r = NDC_HI;
		end else begin
			r = {~q[NDC_W-1], q[NDC_W-2:0]};
		end
		return r;
	endfunction

endpackage

// ===== src/wmd_ifs.sv =====
`timescale 1ns / 1ps

interface wmd_sample_if;
	logic             valid;
	logic             ready;
	wmd_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface wmd_vertex_if;
	logic          valid;
	logic          ready;
	wmd_pkg::ndc_t x_ndc;
	wmd_pkg::ndc_t y_ndc;
	logic [1:0]    vertex_kind;
	logic          run_last;
	logic          wave_last;

	modport source (output valid, output x_ndc, output y_ndc, output vertex_kind,
		output run_last, output wave_last, input ready);
	modport sink (input valid, input x_ndc, input y_ndc, input vertex_kind,
		input run_last, input wave_last, output ready);
endinterface

interface wmd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [wmd_pkg::CFG_IDX_W-1:0]    index;
	logic [wmd_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/waveform_minmax_display_decimator.sv =====
`timescale 1ns / 1ps
// A sample passes the registered gain stage, the sample queue and the result buffer to become
// a vertex. One sample per cycle is taken in line mode and for columns of two or more samples
// while the vertex output is not stalled; a one-sample column yields a min/max pair, and the
// next pair waits for room in the buffer. The serial divider runs two 21-step divisions after
// reset or a size write before queued samples are processed; samples still enter the queue.
// Reset (arst_n, asynchronous, active low) clears counters, queue and handshake state.

module waveform_minmax_display_decimator (
	input  logic         clk,
	input  logic         arst_n,
	wmd_sample_if.sink   sample_ch,
	wmd_vertex_if.source vertex_ch,
	wmd_cfg_if.sink      cfg
);

	logic [wmd_pkg::GAIN_W-1:0] gain;
	wmd_pkg::geo_t              geo;
	logic                       fifo_push;
	wmd_pkg::sample_t           fifo_wdata;
	logic                       fifo_full;
	logic                       fifo_pop;
	wmd_pkg::sample_t           fifo_rdata;
	logic                       fifo_empty;

	wmd_setup u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.gain   (gain),
		.geo    (geo)
	);

	wmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.gain      (gain),
		.full      (fifo_full),
		.push      (fifo_push),
		.y         (fifo_wdata)
	);

	wmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (fifo_wdata),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.pop_data  (fifo_rdata),
		.empty     (fifo_empty)
	);

	wmd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.geo        (geo),
		.head_valid (!fifo_empty),
		.head_y     (fifo_rdata),
		.pop        (fifo_pop),
		.vertex_ch  (vertex_ch)
	);

endmodule

// ===== src/wmd_setup.sv =====
`timescale 1ns / 1ps

module wmd_setup (
	input  logic                       clk,
	input  logic                       arst_n,
	wmd_cfg_if.sink                    cfg,
	output logic [wmd_pkg::GAIN_W-1:0] gain,
	output wmd_pkg::geo_t              geo
);

	logic [wmd_pkg::N_W-1:0]    sample_count_q;
	logic [wmd_pkg::W_W-1:0]    column_count_q;
	logic [wmd_pkg::GAIN_W-1:0] gain_q;

	logic                       wr;
	logic                       size_wr;
	logic [wmd_pkg::N_W-1:0]    n_eff;
	logic [wmd_pkg::W_W-1:0]    w_eff;
	logic [wmd_pkg::IDX_W-1:0]  n_last;
	logic [wmd_pkg::COL_W-1:0]  w_last;
	logic                       env;

	wmd_pkg::setup_state_t      state_q;
	wmd_pkg::setup_state_t      state_d;
	logic [wmd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                       div_done;

	logic [wmd_pkg::DIV_W-1:0]  quo_q;
	logic [wmd_pkg::XR_W-1:0]   rem_q;
	logic [wmd_pkg::XR_W-1:0]   d_q;
	logic [wmd_pkg::SPC_W-1:0]  spc_q;
	logic [wmd_pkg::DIV_W-1:0]  trial;
	logic [wmd_pkg::DIV_W-1:0]  diff;
	logic                       ge;
	logic [wmd_pkg::XR_W-1:0]   rem_next;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;
	assign size_wr   = wr && (cfg.index == wmd_pkg::REG_SAMPLE_COUNT ||
		cfg.index == wmd_pkg::REG_COLUMN_COUNT);

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= wmd_pkg::N_W'(1);
			column_count_q <= wmd_pkg::W_W'(1);
			gain_q         <= wmd_pkg::GAIN_W'(256);
		end else if (wr) begin
			unique case (wmd_pkg::reg_idx_t'(cfg.index))
				wmd_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg.data[wmd_pkg::N_W-1:0];
				wmd_pkg::REG_COLUMN_COUNT: column_count_q <= cfg.data[wmd_pkg::W_W-1:0];
				wmd_pkg::REG_GAIN:         gain_q <= cfg.data[wmd_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign gain = gain_q;

	// Clamp sizes to their legal ranges
	always_comb begin
		if (sample_count_q == '0) begin
			n_eff = wmd_pkg::N_W'(1);
		end else if (sample_count_q > wmd_pkg::N_W'(wmd_pkg::MAX_SAMPLES)) begin
			n_eff = wmd_pkg::N_W'(wmd_pkg::MAX_SAMPLES);
		end else begin
			n_eff = sample_count_q;
		end
		if (column_count_q == '0) begin
			w_eff = wmd_pkg::W_W'(1);
		end else if (column_count_q > wmd_pkg::W_W'(wmd_pkg::MAX_COLUMNS)) begin
			w_eff = wmd_pkg::W_W'(wmd_pkg::MAX_COLUMNS);
		end else begin
			w_eff = column_count_q;
		end
	end

	assign n_last = wmd_pkg::IDX_W'(n_eff - 1'b1);
	assign w_last = wmd_pkg::COL_W'(w_eff - 1'b1);
	assign env    = n_eff > wmd_pkg::N_W'(w_eff);

	// Restoring divider step, one quotient bit per cycle
	assign trial    = {rem_q, quo_q[wmd_pkg::DIV_W-1]};
	assign ge       = trial >= {1'b0, d_q};
	assign diff     = trial - {1'b0, d_q};
	assign rem_next = ge ? diff[wmd_pkg::XR_W-1:0] : trial[wmd_pkg::XR_W-1:0];
	assign div_done = cnt_q == wmd_pkg::DIV_CNT_W'(wmd_pkg::DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wmd_pkg::SU_LOAD_SPC;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == wmd_pkg::SU_RUN_SPC || state_q == wmd_pkg::SU_RUN_STEP) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// Sequence the two divisions: samples per column, then the x step
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wmd_pkg::SU_LOAD_SPC:  state_d = wmd_pkg::SU_RUN_SPC;
			wmd_pkg::SU_RUN_SPC:   if (div_done) state_d = wmd_pkg::SU_LOAD_STEP;
			wmd_pkg::SU_LOAD_STEP: state_d = wmd_pkg::SU_RUN_STEP;
			wmd_pkg::SU_RUN_STEP:  if (div_done) state_d = wmd_pkg::SU_READY;
			wmd_pkg::SU_READY:     state_d = wmd_pkg::SU_READY;
			default:               state_d = wmd_pkg::SU_LOAD_SPC;
		endcase
		if (size_wr) begin
			state_d = wmd_pkg::SU_LOAD_SPC;
		end
	end

	// Divider operands
	always_ff @(posedge clk) begin
		unique case (state_q)
			wmd_pkg::SU_LOAD_SPC: begin
				quo_q <= n_eff;
				rem_q <= '0;
				d_q   <= wmd_pkg::XR_W'(w_eff);
			end
			wmd_pkg::SU_LOAD_STEP: begin
				spc_q <= quo_q;
				quo_q <= wmd_pkg::DIV_W'(wmd_pkg::X_ONE);
				rem_q <= '0;
				d_q   <= env ? wmd_pkg::XR_W'(w_last) : n_last;
			end
			wmd_pkg::SU_RUN_SPC, wmd_pkg::SU_RUN_STEP: begin
				quo_q <= {quo_q[wmd_pkg::DIV_W-2:0], ge};
				rem_q <= rem_next;
			end
			default: ;
		endcase
	end

	always_comb begin
		geo.ready   = state_q == wmd_pkg::SU_READY;
		geo.restart = size_wr;
		geo.env     = env;
		geo.spc     = spc_q;
		geo.n_last  = n_last;
		geo.w_last  = w_last;
		geo.step_a  = quo_q[wmd_pkg::XQ_W-1:0];
		geo.step_b  = rem_q;
		geo.step_d  = d_q;
	end

endmodule

// ===== src/wmd_front.sv =====
`timescale 1ns / 1ps

module wmd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	wmd_sample_if.sink                 sample_ch,
	input  logic [wmd_pkg::GAIN_W-1:0] gain,
	input  logic                       full,
	output logic                       push,
	output wmd_pkg::sample_t           y
);

	localparam int PROD_W = wmd_pkg::SAMPLE_BITS + wmd_pkg::GAIN_W + 1;
	localparam int Q_W    = PROD_W - wmd_pkg::GAIN_FRAC;

	logic                     v_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [Q_W-1:0]    q;
	logic                     fits;
	logic                     acc;

	assign push            = v_s1 && !full;
	assign sample_ch.ready = !v_s1 || push;
	assign acc             = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	// Scale by the Q8.8 gain
	always_ff @(posedge clk) begin
		if (acc) begin
			prod_s1 <= PROD_W'(sample_ch.sample) * PROD_W'($signed({1'b0, gain}));
		end
	end

	// Drop the fraction (floor) and saturate to the sample range
	assign q    = prod_s1[PROD_W-1:wmd_pkg::GAIN_FRAC];
	assign fits = (&q[Q_W-1:wmd_pkg::SAMPLE_BITS-1]) || !(|q[Q_W-1:wmd_pkg::SAMPLE_BITS-1]);

	always_comb begin
		if (fits) begin
			y = q[wmd_pkg::SAMPLE_BITS-1:0];
		end else if (q[Q_W-1]) begin
			y = wmd_pkg::SAMP_LO;
		end else begin
			y = wmd_pkg::SAMP_HI;
		end
	end

endmodule

// ===== src/wmd_fifo.sv =====
`timescale 1ns / 1ps

module wmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wmd_pkg::sample_t push_data,
	output logic             full,
	input  logic             pop,
	output wmd_pkg::sample_t pop_data,
	output logic             empty
);

	wmd_pkg::sample_t mem_q [wmd_pkg::FIFO_DEPTH];
	logic [wmd_pkg::FIFO_AW:0] wr_q;
	logic [wmd_pkg::FIFO_AW:0] rd_q;

	assign empty = wr_q == rd_q;
	assign full  = (wr_q[wmd_pkg::FIFO_AW] != rd_q[wmd_pkg::FIFO_AW]) &&
		(wr_q[wmd_pkg::FIFO_AW-1:0] == rd_q[wmd_pkg::FIFO_AW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q[wmd_pkg::FIFO_AW-1:0]] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_q[wmd_pkg::FIFO_AW-1:0]];

endmodule

// ===== src/wmd_back.sv =====
`timescale 1ns / 1ps

module wmd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  wmd_pkg::geo_t    geo,
	input  logic             head_valid,
	input  wmd_pkg::sample_t head_y,
	output logic             pop,
	wmd_vertex_if.source     vertex_ch
);

	logic [wmd_pkg::IDX_W-1:0] idx_q;
	logic [wmd_pkg::COL_W-1:0] col_q;
	logic [wmd_pkg::SPC_W-1:0] fill_q;
	wmd_pkg::sample_t          min_q;
	wmd_pkg::sample_t          max_q;
	logic [wmd_pkg::XQ_W-1:0]  xq_q;
	logic [wmd_pkg::XR_W-1:0]  xr_q;

	logic                      last;
	logic                      col_end;
	wmd_pkg::sample_t          nmin;
	wmd_pkg::sample_t          nmax;
	logic [1:0]                nres;
	logic [wmd_pkg::XR_W:0]    sum_r;
	logic [wmd_pkg::XR_W:0]    sub_r;
	logic                      wrap;
	logic [wmd_pkg::XQ_W-1:0]  xq_next;
	logic [wmd_pkg::XR_W-1:0]  xr_next;
	wmd_pkg::ndc_t             x_line;
	wmd_pkg::ndc_t             x_col;
	wmd_pkg::vtx_t             v0;
	wmd_pkg::vtx_t             v1;
	wmd_pkg::vtx_t             slot0_q;
	wmd_pkg::vtx_t             slot1_q;
	logic [1:0]                cnt_q;
	logic                      out_acc;
	logic                      buf_free;
	logic                      push;

	// Classify the sample at the head of the queue
	assign last    = idx_q == geo.n_last;
	assign col_end = last || (col_q != geo.w_last && (fill_q + 1'b1) >= geo.spc);
	assign nmin    = (head_y < min_q) ? head_y : min_q;
	assign nmax    = (head_y > max_q) ? head_y : max_q;

	always_comb begin
		if (!geo.env) begin
			nres = 2'd1;
		end else if (col_end) begin
			nres = 2'd2;
		end else begin
			nres = 2'd0;
		end
	end

	// Advance x = floor(k * 65536 / D) by one step of k
	assign sum_r   = {1'b0, xr_q} + {1'b0, geo.step_b};
	assign wrap    = sum_r >= {1'b0, geo.step_d};
	assign sub_r   = sum_r - {1'b0, geo.step_d};
	assign xr_next = wrap ? sub_r[wmd_pkg::XR_W-1:0] : sum_r[wmd_pkg::XR_W-1:0];
	assign xq_next = xq_q + geo.step_a + wmd_pkg::XQ_W'(wrap);

	assign x_line = wmd_pkg::ndc_from_q(xq_q);
	assign x_col  = (geo.w_last == '0) ? '0 : wmd_pkg::ndc_from_q(xq_q);

	always_comb begin
		v0.x         = geo.env ? x_col : x_line;
		v0.y         = geo.env ? nmin : head_y;
		v0.kind      = geo.env ? wmd_pkg::KIND_MIN : wmd_pkg::KIND_LINE;
		v0.run_last  = !geo.env;
		v0.wave_last = !geo.env && last;
		v1.x         = x_col;
		v1.y         = nmax;
		v1.kind      = wmd_pkg::KIND_MAX;
		v1.run_last  = 1'b1;
		v1.wave_last = last;
	end

	assign out_acc  = vertex_ch.valid && vertex_ch.ready;
	assign buf_free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_acc);
	assign pop      = head_valid && geo.ready && !geo.restart && (nres == 2'd0 || buf_free);
	assign push     = pop && nres != 2'd0;

	// Waveform counters and running envelope
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			col_q  <= '0;
			fill_q <= '0;
			min_q  <= wmd_pkg::SAMP_HI;
			max_q  <= wmd_pkg::SAMP_LO;
			xq_q   <= '0;
			xr_q   <= '0;
		end else if (geo.restart || (pop && last)) begin
			idx_q  <= '0;
			col_q  <= '0;
			fill_q <= '0;
			min_q  <= wmd_pkg::SAMP_HI;
			max_q  <= wmd_pkg::SAMP_LO;
			xq_q   <= '0;
			xr_q   <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 1'b1;
			if (!geo.env || col_end) begin
				xq_q <= xq_next;
				xr_q <= xr_next;
			end
			if (geo.env) begin
				if (col_end) begin
					col_q  <= col_q + 1'b1;
					fill_q <= '0;
					min_q  <= wmd_pkg::SAMP_HI;
					max_q  <= wmd_pkg::SAMP_LO;
				end else begin
					fill_q <= fill_q + 1'b1;
					min_q  <= nmin;
					max_q  <= nmax;
				end
			end
		end
	end

	// Two-entry result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= nres;
		end else if (out_acc) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= v0;
			slot1_q <= v1;
		end else if (out_acc) begin
			slot0_q <= slot1_q;
		end
	end

	assign vertex_ch.valid       = cnt_q != 2'd0;
	assign vertex_ch.x_ndc       = slot0_q.x;
	assign vertex_ch.y_ndc       = slot0_q.y;
	assign vertex_ch.vertex_kind = slot0_q.kind;
	assign vertex_ch.run_last    = slot0_q.run_last;
	assign vertex_ch.wave_last   = slot0_q.wave_last;

endmodule

// ===== src/wmd_chk.sv =====
`timescale 1ns / 1ps

module wmd_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                valid,
	input logic                ready,
	input wmd_pkg::ndc_t       x_ndc,
	input wmd_pkg::ndc_t       y_ndc,
	input logic [1:0]          vertex_kind,
	input logic                run_last,
	input logic                wave_last
);

	// Hold a stalled vertex
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(x_ndc) && $stable(y_ndc) &&
		$stable(vertex_kind) && $stable(run_last) && $stable(wave_last))
		else $error("vertex changed while stalled");

	// A column minimum is followed at once by its maximum at the same x
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && vertex_kind == wmd_pkg::KIND_MIN |=>
		valid && vertex_kind == wmd_pkg::KIND_MAX && $stable(x_ndc))
		else $error("minimum vertex not followed by maximum");

	// A column minimum never closes a run or the waveform
	a_min_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid && vertex_kind == wmd_pkg::KIND_MIN |-> !run_last && !wave_last)
		else $error("minimum vertex carries a last flag");

	// The final vertex closes its run and is a line point or a maximum
	a_wave_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && wave_last |-> run_last &&
		(vertex_kind == wmd_pkg::KIND_LINE || vertex_kind == wmd_pkg::KIND_MAX))
		else $error("bad final vertex");

endmodule

bind waveform_minmax_display_decimator wmd_chk u_wmd_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (vertex_ch.valid),
	.ready       (vertex_ch.ready),
	.x_ndc       (vertex_ch.x_ndc),
	.y_ndc       (vertex_ch.y_ndc),
	.vertex_kind (vertex_ch.vertex_kind),
	.run_last    (vertex_ch.run_last),
	.wave_last   (vertex_ch.wave_last)
);

// ===== tb/sv/tb_waveform_minmax_display_decimator.sv =====
`timescale 1ns / 1ps

module tb_waveform_minmax_display_decimator;

	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 500000;
	localparam logic [wmd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	wmd_sample_if sample_ch ();
	wmd_vertex_if vertex_ch ();
	wmd_cfg_if    cfg ();

	waveform_minmax_display_decimator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.vertex_ch (vertex_ch),
		.cfg       (cfg)
	);

	// Traffic shaping, in percent per cycle
	int idle_pct  = 0;
	int stall_pct = 0;

	// Run statistics
	int errors          = 0;
	int samples_sent    = 0;
	int vertices_seen   = 0;
	int waves_finished  = 0;
	int reg_writes      = 0;
	int unsigned cycles = 0;

	// Shadow registers and decimator walk state
	int unsigned reg_n    = 1;
	int unsigned reg_w    = 1;
	int unsigned reg_gain = 256;
	int unsigned wave_pos = 0;
	int unsigned col_pos  = 0;
	int unsigned col_fill = 0;
	int unsigned col_len  = 1;
	int          env_lo   = 32767;
	int          env_hi   = -32768;
	bit          env_mode = 1'b0;

	wmd_pkg::vtx_t expected_vertices[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// Randomize vertex backpressure
	always @(negedge clk) begin
		vertex_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic void restart_walk();
		wave_pos = 0;
		col_pos  = 0;
		col_fill = 0;
		col_len  = 1;
		env_lo   = 32767;
		env_hi   = -32768;
		env_mode = 1'b0;
	endfunction

	function automatic int unsigned active_samples();
		if (reg_n < 1) return 1;
		if (reg_n > wmd_pkg::MAX_SAMPLES) return wmd_pkg::MAX_SAMPLES;
		return reg_n;
	endfunction

	function automatic int unsigned active_columns();
		if (reg_w < 1) return 1;
		if (reg_w > wmd_pkg::MAX_COLUMNS) return wmd_pkg::MAX_COLUMNS;
		return reg_w;
	endfunction

	// Q8.8 gain with floor, clamped to Q1.15
	function automatic int scaled_level(input wmd_pkg::sample_t s);
		longint p;
		longint q;
		p = longint'(s) * longint'(reg_gain);
		q = p >>> wmd_pkg::GAIN_FRAC;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return int'(q);
	endfunction

	// floor(pos * 65536 / span) - 32768, +1 saturated
	function automatic int ndc_position(input int unsigned pos, input int unsigned span);
		longint q;
		q = (longint'(pos) << 16) / longint'(span) - 32768;
		if (q > 32767) q = 32767;
		return int'(q);
	endfunction

	function automatic void apply_register(input logic [wmd_pkg::CFG_IDX_W-1:0] idx,
			input logic [wmd_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			wmd_pkg::REG_SAMPLE_COUNT: begin
				reg_n = 32'(value[wmd_pkg::N_W-1:0]);
				restart_walk();
			end
			wmd_pkg::REG_COLUMN_COUNT: begin
				reg_w = 32'(value[wmd_pkg::W_W-1:0]);
				restart_walk();
			end
			wmd_pkg::REG_GAIN: begin
				reg_gain = 32'(value[wmd_pkg::GAIN_W-1:0]);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void queue_vertex(input int x, input int y, input wmd_pkg::kind_t kind,
			input bit run_end, input bit wave_end);
		wmd_pkg::vtx_t v;
		v.x         = wmd_pkg::ndc_t'(x);
		v.y         = wmd_pkg::sample_t'(y);
		v.kind      = kind;
		v.run_last  = run_end;
		v.wave_last = wave_end;
		expected_vertices.insert(expected_vertices.size(), v);
	endfunction

	// Advance the decimator by one sample and queue the vertices it yields
	function automatic void predict_vertices(input wmd_pkg::sample_t s);
		int unsigned n;
		int unsigned w;
		int          y;
		int          x;
		bit          at_end;
		n = active_samples();
		w = active_columns();
		y = scaled_level(s);
		if (wave_pos == 0) begin
			env_mode = (n > w);
			col_len  = n / w;
			if (col_len < 1) col_len = 1;
			col_pos  = 0;
			col_fill = 0;
			env_lo   = 32767;
			env_hi   = -32768;
		end
		at_end = (wave_pos + 1 >= n);
		if (at_end) waves_finished++;

		if (!env_mode) begin
			x = (n > 1) ? ndc_position(wave_pos, n - 1) : -32768;
			queue_vertex(x, y, wmd_pkg::KIND_LINE, 1'b1, at_end);
			if (at_end) restart_walk();
			else wave_pos++;
			return;
		end

		if (y < env_lo) env_lo = y;
		if (y > env_hi) env_hi = y;
		col_fill++;
		if (at_end || (col_pos + 1 < w && col_fill >= col_len)) begin
			x = (w > 1) ? ndc_position(col_pos, w - 1) : 0;
			queue_vertex(x, env_lo, wmd_pkg::KIND_MIN, 1'b0, 1'b0);
			queue_vertex(x, env_hi, wmd_pkg::KIND_MAX, 1'b1, at_end);
			if (at_end) begin
				restart_walk();
			end else begin
				wave_pos++;
				col_pos++;
				col_fill = 0;
				env_lo   = 32767;
				env_hi   = -32768;
			end
		end else begin
			wave_pos++;
		end
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compare each vertex transaction with the oldest expectation
	always @(posedge clk) begin : check_vertices
		wmd_pkg::vtx_t want;
		if (arst_n && vertex_ch.valid && vertex_ch.ready) begin
			vertices_seen++;
			if (expected_vertices.size() == 0) begin
				$display("%0t: unexpected vertex, expected none, actual x %0d y %0d kind %0d",
					$time, vertex_ch.x_ndc, vertex_ch.y_ndc, vertex_ch.vertex_kind);
				errors++;
			end else begin
				want = expected_vertices.pop_front();
				check_field("x_ndc", int'(want.x), int'(vertex_ch.x_ndc));
				check_field("y_ndc", int'(want.y), int'(vertex_ch.y_ndc));
				check_field("vertex_kind", int'(want.kind), int'(vertex_ch.vertex_kind));
				check_field("run_last", int'(want.run_last), int'(vertex_ch.run_last));
				check_field("wave_last", int'(want.wave_last), int'(vertex_ch.wave_last));
			end
		end
	end

	// Send one sample transaction, idling first at random
	task automatic push_sample(input wmd_pkg::sample_t s);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			sample_ch.valid  <= 1'b0;
			sample_ch.sample <= wmd_pkg::sample_t'($urandom);
		end
		@(negedge clk);
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		do @(posedge clk); while (!sample_ch.ready);
		predict_vertices(s);
		samples_sent++;
	endtask

	// Drop the sample stream, drain all vertices and let the pipeline empty
	task automatic settle_block();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [wmd_pkg::CFG_IDX_W-1:0] idx,
			input logic [wmd_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		apply_register(idx, value);
		reg_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_geometry(input logic [wmd_pkg::CFG_DATA_W-1:0] n,
			input logic [wmd_pkg::CFG_DATA_W-1:0] w, input logic [wmd_pkg::CFG_DATA_W-1:0] g);
		settle_block();
		write_register(wmd_pkg::REG_SAMPLE_COUNT, n);
		write_register(wmd_pkg::REG_COLUMN_COUNT, w);
		write_register(wmd_pkg::REG_GAIN, g);
	endtask

	function automatic wmd_pkg::sample_t random_level();
		case ($urandom_range(9))
			0: return wmd_pkg::SAMP_HI;
			1: return wmd_pkg::SAMP_LO;
			2: return '0;
			3, 4: return wmd_pkg::sample_t'($signed($urandom_range(510)) - 255);
			default: return wmd_pkg::sample_t'($urandom);
		endcase
	endfunction

	function automatic int pick_length();
		case ($urandom_range(9))
			0: return 1;
			1, 2, 3, 4, 5: return $urandom_range(24, 2);
			6, 7, 8: return $urandom_range(64, 25);
			default: return $urandom_range(160, 65);
		endcase
	endfunction

	function automatic int pick_width(input int n);
		case ($urandom_range(9))
			0: return 1;
			1, 2, 3, 4, 5, 6: return $urandom_range(20, 1);
			7: return n;
			8: return (n > 1) ? n - 1 : 1;
			default: return $urandom_range(wmd_pkg::MAX_COLUMNS, 21);
		endcase
	endfunction

	// Line strip points, both saturation limits, x reaching +1
	task automatic test_line_mode();
		set_geometry(4, 8, 256);
		push_sample(wmd_pkg::SAMP_HI);
		push_sample(wmd_pkg::SAMP_LO);
		push_sample(16'sd0);
		push_sample(-16'sd1);
		set_geometry(2, 2, 256);
		push_sample(16'sh1234);
		push_sample(-16'sh1234);
	endtask

	// Min/max pairs, remainder in the last column, a single column
	task automatic test_envelope_mode();
		set_geometry(7, 3, 256);
		push_sample(16'sd100);
		push_sample(-16'sd200);
		push_sample(16'sd300);
		push_sample(wmd_pkg::SAMP_LO);
		push_sample(wmd_pkg::SAMP_HI);
		push_sample(16'sd5);
		push_sample(-16'sd5);
		set_geometry(3, 1, 512);
		push_sample(wmd_pkg::SAMP_HI);
		push_sample(wmd_pkg::SAMP_LO);
		push_sample(16'sh4000);
	endtask

	// Zero sizes clamp to one; back-to-back single-sample waveforms
	task automatic test_single_sample();
		set_geometry(0, 0, 256);
		push_sample(16'sd1);
		push_sample(wmd_pkg::SAMP_LO);
	endtask

	// Zero and full gain, floor on negatives, gain change mid-waveform
	task automatic test_gain_edges();
		set_geometry(2, 4, 0);
		push_sample(wmd_pkg::SAMP_HI);
		push_sample(wmd_pkg::SAMP_LO);
		settle_block();
		write_register(wmd_pkg::REG_GAIN, 21'h1FFFFF);
		push_sample(-16'sd1);
		push_sample(wmd_pkg::SAMP_HI);
		set_geometry(4, 8, 384);
		push_sample(16'sd1000);
		push_sample(-16'sd1000);
		settle_block();
		write_register(wmd_pkg::REG_GAIN, 128);
		push_sample(16'sd1000);
		push_sample(-16'sd1001);
	endtask

	// Size writes abandon a waveform; an unknown index is ignored
	task automatic test_abandon();
		set_geometry(6, 2, 256);
		push_sample(16'sd10);
		push_sample(16'sd20);
		push_sample(-16'sd30);
		push_sample(16'sd40);
		settle_block();
		write_register(wmd_pkg::REG_COLUMN_COUNT, 3);
		write_register(REG_UNUSED, 21'h1FFFFF);
		for (int i = 0; i < 6; i++) push_sample(random_level());
		set_geometry(5, 8, 256);
		push_sample(16'sd7);
		push_sample(16'sd8);
		settle_block();
		write_register(wmd_pkg::REG_SAMPLE_COUNT, 3);
		for (int i = 0; i < 3; i++) push_sample(random_level());
	endtask

	// Oversized registers clamp to the maximum sizes
	task automatic test_size_clamp();
		set_geometry(21'h1FFFFF, 21'h1FFF, 256);
		for (int i = 0; i < 260; i++) push_sample(random_level());
		set_geometry(3, 21'h1FFFFF, 256);
		for (int i = 0; i < 3; i++) push_sample(random_level());
	endtask

	// Random waveforms: mostly complete, some cut short, some with a gain change
	task automatic test_random_traffic(input int idle_share, input int stall_share,
			input int budget);
		int               sent;
		int               n;
		int               w;
		int               cut;
		int               shape;
		int               peak;
		int               level;
		int unsigned      g;
		bit               fresh;
		wmd_pkg::sample_t wave[];
		sent      = 0;
		n         = 1;
		fresh     = 1'b1;
		idle_pct  = idle_share;
		stall_pct = stall_share;
		while (sent < budget) begin
			shape = $urandom_range(99);
			settle_block();
			if (fresh || $urandom_range(4) != 0) begin
				n = pick_length();
				w = pick_width(n);
				write_register(wmd_pkg::REG_SAMPLE_COUNT, n);
				write_register(wmd_pkg::REG_COLUMN_COUNT, {8'($urandom), 13'(w)});
			end
			wave = new[n];
			peak = 0;
			foreach (wave[i]) begin
				wave[i] = random_level();
				level = int'(wave[i]);
				if (level < 0) level = -level;
				if (level > peak) peak = level;
			end
			case ($urandom_range(3))
				0: g = 256;
				1: begin
					g = (peak == 0) ? 256 : (256 * 32768) / peak;
					if (g > 65535) g = 65535;
				end
				2: g = $urandom_range(65535);
				default: g = $urandom_range(1) ? 0 : 65535;
			endcase
			write_register(wmd_pkg::REG_GAIN, {5'($urandom), 16'(g)});
			cut   = (n > 1) ? $urandom_range(n - 1, 1) : n;
			fresh = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (shape < 12 && i == cut) begin
					fresh = 1'b1;
					break;
				end
				if (shape >= 12 && shape < 25 && i == cut) begin
					settle_block();
					write_register(wmd_pkg::REG_GAIN, 21'($urandom_range(65535)));
				end
				push_sample(wave[i]);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		cfg.valid        = 1'b0;
		cfg.index        = '0;
		cfg.data         = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_line_mode();
		test_envelope_mode();
		test_single_sample();
		test_gain_edges();
		test_abandon();
		test_size_clamp();
		test_random_traffic(0, 0, 90);
		test_random_traffic(80, 0, 90);
		test_random_traffic(0, 80, 90);
		test_random_traffic(24, 24, 90);
		settle_block();

		$display("Sent %0d samples in %0d finished waveforms, checked %0d vertices.",
			samples_sent, waves_finished, vertices_seen);
		$display("Made %0d register writes across line, envelope, clamp and abandon cases.",
			reg_writes);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/wmd_pkg.sv
src/wmd_ifs.sv
src/wmd_setup.sv
src/wmd_front.sv
src/wmd_fifo.sv
src/wmd_back.sv
src/waveform_minmax_display_decimator.sv
src/wmd_chk.sv
tb/sv/tb_waveform_minmax_display_decimator.sv
